/* rtl/wear_leveled_counter_log_unit_macros.svh */
// assertion helpers used by the top-level file that checks this unit
`ifndef WEAR_LEVELED_COUNTER_LOG_UNIT_MACROS_SVH
`define WEAR_LEVELED_COUNTER_LOG_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define WLC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WLC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/wlc_pkg.sv */
package wlc_pkg;

	localparam int SECTOR_COUNT     = 5;
	localparam int SLOTS_PER_SECTOR = 128;
	localparam int SECTOR_BYTES     = 512;

	localparam int WORD_W      = 32;
	localparam int ADDR_W      = 16;
	localparam int BYTE_W      = 8;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;

	localparam int SLOT_BITS   = $clog2(SLOTS_PER_SECTOR);
	localparam int SECTOR_BITS = $clog2(SECTOR_COUNT);
	localparam int HI_W        = WORD_W - SLOT_BITS;

	// sector = hi mod SECTOR_COUNT via round-up reciprocal, exact for hi < 2**HI_W
	localparam int RECIP_SHIFT = HI_W + SECTOR_BITS;
	localparam int RECIP_W     = HI_W + 2;
	localparam logic [63:0] RECIP =
		((64'd1 << RECIP_SHIFT) + 64'(SECTOR_COUNT) - 64'd1) / 64'(SECTOR_COUNT);
	localparam int PROD_W      = HI_W + RECIP_W;
	localparam int QUO_W       = PROD_W - RECIP_SHIFT;

	localparam logic [WORD_W-1:0] MAX_VALID = 32'h7FFF_FFFF;

	localparam int SCAN_W = 10;
	localparam logic [SCAN_W-1:0] SCAN_SLOT_MAX = '1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic OP_SAVE = 1'b0;
	localparam logic OP_SCAN = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] REG_BASE   = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_ENDIAN = 1'b1;

	typedef enum logic [1:0] {
		KIND_ERASE   = 2'd0,
		KIND_PROGRAM = 2'd1,
		KIND_REPORT  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_VALID    = 2'd0,
		STATUS_NONE     = 2'd1,
		STATUS_SEQ_FAIL = 2'd2
	} status_t;

	typedef struct packed {
		logic              is_report;
		logic              erase;
		logic [ADDR_W-1:0] sector_base;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] value;
		status_t           status;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

/* rtl/wlc_queue.sv */
module wlc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  wlc_pkg::entry_t push_entry,
	input  logic            pop,
	output wlc_pkg::entry_t head,
	output wlc_pkg::qstat_t stat
);

	wlc_pkg::entry_t                mem_q [wlc_pkg::QUEUE_DEPTH];
	logic [wlc_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [wlc_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [wlc_pkg::QPTR_W:0]       cnt_q;

	assign stat.full  = (cnt_q == (wlc_pkg::QPTR_W + 1)'(wlc_pkg::QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

/* rtl/wlc_front.sv */
module wlc_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         opcode,
	input  logic [wlc_pkg::WORD_W-1:0]   count_value,
	input  logic [wlc_pkg::WORD_W-1:0]   stored_word,
	input  logic                         scan_last,
	input  logic [wlc_pkg::ADDR_W-1:0]   base_addr,
	input  wlc_pkg::qstat_t              qstat,
	output logic                         push,
	output wlc_pkg::entry_t              entry
);

	logic [wlc_pkg::WORD_W-1:0]      idx_in;
	logic [wlc_pkg::RECIP_W-1:0]     recip_c;
	logic [wlc_pkg::PROD_W-1:0]      prod_in;

	logic                            valid_s1;
	logic                            op_s1;
	logic [wlc_pkg::WORD_W-1:0]      count_s1;
	logic [wlc_pkg::HI_W-1:0]        hi_s1;
	logic [wlc_pkg::SLOT_BITS-1:0]   slot_s1;
	logic [wlc_pkg::PROD_W-1:0]      prod_s1;
	logic [wlc_pkg::WORD_W-1:0]      word_s1;
	logic                            last_s1;

	logic [wlc_pkg::SCAN_W-1:0]      scan_slot_q;
	logic [wlc_pkg::WORD_W-1:0]      best_q;
	logic                            best_found_q;
	logic                            best_first_q;
	logic [wlc_pkg::WORD_W-1:0]      best_pred_q;
	logic [wlc_pkg::WORD_W-1:0]      prev_q;

	logic [wlc_pkg::QUO_W-1:0]       quo;
	logic [wlc_pkg::HI_W-1:0]        quo_x;
	logic [wlc_pkg::SECTOR_BITS-1:0] sector;
	logic [wlc_pkg::ADDR_W-1:0]      sector_base;
	logic [wlc_pkg::ADDR_W-1:0]      slot_addr;

	logic                            upd;
	logic [wlc_pkg::WORD_W-1:0]      nbest;
	logic                            nfound;
	logic                            nfirst;
	logic [wlc_pkg::WORD_W-1:0]      npred;
	logic [wlc_pkg::WORD_W-1:0]      pred;
	logic [wlc_pkg::WORD_W-1:0]      rep_count;
	wlc_pkg::status_t                rep_status;

	logic                            need_push;
	logic                            advance;

	// slot index of a save is count-1; split into sector and slot-in-sector
	assign idx_in  = count_value - 1'b1;
	assign recip_c = wlc_pkg::RECIP[wlc_pkg::RECIP_W-1:0];
	assign prod_in = wlc_pkg::PROD_W'(idx_in[wlc_pkg::WORD_W-1:wlc_pkg::SLOT_BITS])
		* wlc_pkg::PROD_W'(recip_c);

	assign quo         = prod_s1[wlc_pkg::PROD_W-1:wlc_pkg::RECIP_SHIFT];
	assign quo_x       = wlc_pkg::HI_W'(quo) * wlc_pkg::HI_W'(wlc_pkg::SECTOR_COUNT);
	assign sector      = wlc_pkg::SECTOR_BITS'(hi_s1 - quo_x);
	assign sector_base = base_addr
		+ wlc_pkg::ADDR_W'(sector) * wlc_pkg::ADDR_W'(wlc_pkg::SECTOR_BYTES);
	assign slot_addr   = sector_base + (wlc_pkg::ADDR_W'(slot_s1) << 2);

	// running maximum over the pass, first of equal words wins
	always_comb begin
		upd    = (word_s1 <= wlc_pkg::MAX_VALID) && (word_s1 > best_q);
		nbest  = upd ? word_s1 : best_q;
		nfound = upd | best_found_q;
		nfirst = upd ? (scan_slot_q == '0) : best_first_q;
		npred  = upd ? prev_q : best_pred_q;
		// slot 0 wraps to the final word of the pass
		pred   = nfirst ? word_s1 : npred;
		if (!nfound) begin
			rep_count  = '0;
			rep_status = wlc_pkg::STATUS_NONE;
		end else if (nbest - pred == 32'd1) begin
			rep_count  = nbest;
			rep_status = wlc_pkg::STATUS_VALID;
		end else begin
			rep_count  = '0;
			rep_status = wlc_pkg::STATUS_SEQ_FAIL;
		end
	end

	assign need_push = (op_s1 == wlc_pkg::OP_SAVE) || last_s1;
	assign advance   = valid_s1 && (!need_push || !qstat.full);
	assign in_ready  = !valid_s1 || advance;
	assign push      = valid_s1 && need_push && !qstat.full;

	always_comb begin
		entry.is_report   = (op_s1 == wlc_pkg::OP_SCAN);
		entry.erase       = (slot_s1 == '0);
		entry.sector_base = sector_base;
		entry.addr        = slot_addr;
		entry.value       = entry.is_report ? rep_count : count_s1;
		entry.status      = entry.is_report ? rep_status : wlc_pkg::STATUS_VALID;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			scan_slot_q  <= '0;
			best_q       <= '0;
			best_found_q <= 1'b0;
			best_first_q <= 1'b0;
			best_pred_q  <= '0;
			prev_q       <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance && op_s1 == wlc_pkg::OP_SCAN) begin
				if (last_s1) begin
					scan_slot_q  <= '0;
					best_q       <= '0;
					best_found_q <= 1'b0;
					best_first_q <= 1'b0;
					best_pred_q  <= '0;
					prev_q       <= '0;
				end else begin
					best_q       <= nbest;
					best_found_q <= nfound;
					best_first_q <= nfirst;
					best_pred_q  <= npred;
					prev_q       <= word_s1;
					if (scan_slot_q != wlc_pkg::SCAN_SLOT_MAX) begin
						scan_slot_q <= scan_slot_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1    <= opcode;
			count_s1 <= count_value;
			hi_s1    <= idx_in[wlc_pkg::WORD_W-1:wlc_pkg::SLOT_BITS];
			slot_s1  <= idx_in[wlc_pkg::SLOT_BITS-1:0];
			prod_s1  <= prod_in;
			word_s1  <= stored_word;
			last_s1  <= scan_last;
		end
	end

endmodule

/* rtl/wlc_back.sv */
module wlc_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wlc_pkg::entry_t            head,
	input  wlc_pkg::qstat_t            qstat,
	input  logic                       big_endian,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 result_kind,
	output logic [wlc_pkg::ADDR_W-1:0] flash_address,
	output logic [wlc_pkg::BYTE_W-1:0] program_byte,
	output logic [wlc_pkg::WORD_W-1:0] recovered_count,
	output logic [1:0]                 recovery_status,
	output logic                       last_of_run
);

	logic                       out_valid_q;
	logic [2:0]                 step_q;
	wlc_pkg::kind_t             kind_q;
	logic [wlc_pkg::ADDR_W-1:0] addr_q;
	logic [wlc_pkg::BYTE_W-1:0] byte_q;
	logic [wlc_pkg::WORD_W-1:0] count_q;
	wlc_pkg::status_t           status_q;
	logic                       last_q;

	logic       load;
	logic [2:0] eff;
	logic [1:0] pi;
	logic [1:0] bsel;
	logic       last_beat;
	logic [wlc_pkg::BYTE_W-1:0] byte_sel;

	// step 0 is the erase beat, steps 1..4 are the byte programs
	assign load      = !qstat.empty && (!out_valid_q || out_ready);
	assign eff       = (step_q == 3'd0 && !head.erase) ? 3'd1 : step_q;
	assign pi        = 2'(eff - 3'd1);
	assign bsel      = big_endian ? (2'd3 - pi) : pi;
	assign byte_sel  = wlc_pkg::BYTE_W'(head.value >> {bsel, 3'b000});
	assign last_beat = head.is_report || (eff == 3'd4);
	assign pop       = load && last_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				step_q      <= last_beat ? 3'd0 : eff + 3'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (head.is_report) begin
				kind_q   <= wlc_pkg::KIND_REPORT;
				addr_q   <= '0;
				byte_q   <= '0;
				count_q  <= head.value;
				status_q <= head.status;
				last_q   <= 1'b1;
			end else if (eff == 3'd0) begin
				kind_q   <= wlc_pkg::KIND_ERASE;
				addr_q   <= head.sector_base;
				byte_q   <= '0;
				count_q  <= '0;
				status_q <= wlc_pkg::STATUS_VALID;
				last_q   <= 1'b0;
			end else begin
				kind_q   <= wlc_pkg::KIND_PROGRAM;
				addr_q   <= head.addr + wlc_pkg::ADDR_W'(pi);
				byte_q   <= byte_sel;
				count_q  <= '0;
				status_q <= wlc_pkg::STATUS_VALID;
				last_q   <= (eff == 3'd4);
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign result_kind     = kind_q;
	assign flash_address   = addr_q;
	assign program_byte    = byte_q;
	assign recovered_count = count_q;
	assign recovery_status = status_q;
	assign last_of_run     = last_q;

endmodule

/* rtl/wear_leveled_counter_log_unit.sv */
// the first result beat passes the s1 register, the queue and the output register
// throughput: one input beat per cycle unless a save or last scan hits a full queue;
// a non-last scan word makes no result; a save makes 4 or 5 result beats, drained
// one per cycle by the output register while out_ready is high; the 4-entry queue
// absorbs bursts; reset (arst_n low, asynchronous) empties the pipeline and queue,
// clears the scan state, sets base address 0 and most-significant-byte-first order
`include "wear_leveled_counter_log_unit_macros.svh"

module wear_leveled_counter_log_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [wlc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [wlc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            opcode,
	input  logic [wlc_pkg::WORD_W-1:0]      count_value,
	input  logic [wlc_pkg::WORD_W-1:0]      stored_word,
	input  logic                            scan_last,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      result_kind,
	output logic [wlc_pkg::ADDR_W-1:0]      flash_address,
	output logic [wlc_pkg::BYTE_W-1:0]      program_byte,
	output logic [wlc_pkg::WORD_W-1:0]      recovered_count,
	output logic [1:0]                      recovery_status,
	output logic                            last_of_run
);

	logic [wlc_pkg::ADDR_W-1:0] base_q;
	logic                       endian_q;

	logic            q_push;
	logic            q_pop;
	wlc_pkg::entry_t q_in;
	wlc_pkg::entry_t q_head;
	wlc_pkg::qstat_t q_stat;

	logic            erase_beat;
	logic            report_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			endian_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wlc_pkg::REG_BASE:   base_q   <= cfg_data;
				wlc_pkg::REG_ENDIAN: endian_q <= cfg_data[0];
			endcase
		end
	end

	wlc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.count_value (count_value),
		.stored_word (stored_word),
		.scan_last   (scan_last),
		.base_addr   (base_q),
		.qstat       (q_stat),
		.push        (q_push),
		.entry       (q_in)
	);

	wlc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.pop        (q_pop),
		.head       (q_head),
		.stat       (q_stat)
	);

	wlc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (q_head),
		.qstat           (q_stat),
		.big_endian      (endian_q),
		.pop             (q_pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.result_kind     (result_kind),
		.flash_address   (flash_address),
		.program_byte    (program_byte),
		.recovered_count (recovered_count),
		.recovery_status (recovery_status),
		.last_of_run     (last_of_run)
	);

	assign erase_beat  = out_valid && (result_kind == wlc_pkg::KIND_ERASE);
	assign report_beat = out_valid && (result_kind == wlc_pkg::KIND_REPORT);

	`WLC_ASSERT_IMPLIES(a_push_has_room, q_push, !q_stat.full || q_pop, "push into full queue")
	`WLC_ASSERT_NEXT(a_back_drains, !q_stat.empty && !out_valid, out_valid, "queued work not issued")
	`WLC_ASSERT_IMPLIES(a_erase_shape, erase_beat, !last_of_run && program_byte == '0, "bad erase")
	`WLC_ASSERT_IMPLIES(a_report_shape, report_beat, last_of_run && flash_address == '0, "bad report")

endmodule
